@@ src/ddc_pkg.sv @@
// ----------------------------------------------------------------------------
// ddc_pkg: shared definitions for the decimal display counter
// Widths, limits, register indexes and the records that travel between the
// front end, the request queue and the decimal converter.
// ----------------------------------------------------------------------------
package ddc_pkg;

  // Number of decimal digits the counter may use (1..8).
  localparam int DIGITS  = 8;
  // Digit slots carried on the result bus, independent of DIGITS.
  localparam int SLOTS   = 8;
  localparam int COUNT_W = 27;
  localparam int AMT_W   = 32;
  // Signed width that holds counter plus amount without wrapping.
  localparam int SUM_W   = 34;
  localparam int BCD_W   = 4 * DIGITS;
  localparam int STEP_W  = $clog2(COUNT_W + 1);
  localparam int FDC_W   = 4;
  localparam int CFG_IDX_W = 2;

  // Largest value that fits in DIGITS decimal digits.
  localparam logic [SUM_W-1:0] LIMIT = SUM_W'(10 ** DIGITS - 1);

  // Request queue depth (a power of two).
  localparam int QDEPTH = 2;
  localparam int QA_W   = $clog2(QDEPTH);

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_LEADING_ZERO_FILL = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_FIXED_DIGIT_COUNT = CFG_IDX_W'(1);

  // Operation codes of an input request.
  localparam logic OP_ADD = 1'b0;
  localparam logic OP_SET = 1'b1;

  // One classified request: the new counter value and the reject flag.
  typedef struct packed {
    logic               rejected;
    logic [COUNT_W-1:0] count;
  } ddc_entry_t;

  // Queue status seen by both sides.
  typedef struct packed {
    logic full;
    logic empty;
  } ddc_qstat_t;

  // One finished result.
  typedef struct packed {
    logic [SLOTS-1:0]        mask;
    logic [SLOTS-1:0][3:0]   digits;
    logic [COUNT_W-1:0]      count;
  } ddc_result_t;

endpackage

@@ src/decimal_display_counter.sv @@
// ----------------------------------------------------------------------------
// decimal_display_counter: counter shown as decimal digits with blanking
// The decimal converter takes one queued value at a time, bit-serially:
// 27 shift steps plus load and format. The front end takes requests back
// to back while its two-entry queue has room.
// Reset: synchronous, active low; counter 0, leading zero fill off, count 8.
// ----------------------------------------------------------------------------
module decimal_display_counter
  import ddc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  // Configuration write channel.
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [FDC_W-1:0]     cfg_data,
  // Input request stream.
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [31:0]          in_tdata,   // [31:0] amount
  input  logic                 in_tuser,   // [0] op
  // Result stream.
  output logic                 out_tvalid,
  input  logic                 out_tready,
  // [26:0] count, [30:27] digit_0, [34:31] digit_1, [38:35] digit_2,
  // [42:39] digit_3, [46:43] digit_4, [50:47] digit_5, [54:51] digit_6,
  // [58:55] digit_7, [66:59] visible_mask, [71:67] zero
  output logic [71:0]          out_tdata,
  output logic                 out_tuser   // [0] rejected
);

  // Configuration registers; the user writes them only while the block is idle
  // (the block does not enforce it); the converter reads them when formatting.
  logic             lzf_r;
  logic [FDC_W-1:0] fdc_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lzf_r <= 1'b0;
      fdc_r <= FDC_W'(8);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_LEADING_ZERO_FILL: lzf_r <= cfg_data[0];
        CFG_FIXED_DIGIT_COUNT: fdc_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // The front end owns the counter: each accepted request updates it at once,
  // so the next request can follow in the very next cycle while the queue
  // has room. The queue carries the new value and reject flag to the converter.
  ddc_qstat_t  qstat;
  logic        push;
  ddc_entry_t  push_entry;
  logic        pop;
  ddc_entry_t  pop_entry;
  ddc_result_t result;
  logic        result_rej;

  ddc_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_op      (in_tuser),
    .in_amount  (in_tdata),
    .qstat      (qstat),
    .push       (push),
    .push_entry (push_entry)
  );

  ddc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .pop_entry  (pop_entry),
    .qstat      (qstat)
  );

  // The converter holds a finished result in its output register while it
  // already starts on the next queued value.
  ddc_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .qstat        (qstat),
    .pop_entry    (pop_entry),
    .pop          (pop),
    .lzf          (lzf_r),
    .fdc          (fdc_r),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .out_result   (result),
    .out_rejected (result_rej)
  );

  assign out_tdata = {5'b0, result.mask, result.digits, result.count};
  assign out_tuser = result_rej;

  // Every digit within range must be a legal decimal digit.
  logic digits_ok;
  always_comb begin
    digits_ok = 1'b1;
    for (int i = 0; i < SLOTS; i++) begin
      if (result.digits[i] > 4'd9) begin
        digits_ok = 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_units_shown: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> result.mask[0])
    else $error("units digit not marked visible");

  a_digits_decimal: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> digits_ok)
    else $error("converter produced a non-decimal digit");

  a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ({{(SUM_W - COUNT_W){1'b0}}, result.count} <= LIMIT))
    else $error("count exceeds the digit limit");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");
`endif

endmodule

@@ src/ddc_front.sv @@
// ----------------------------------------------------------------------------
// ddc_front: request intake and counter update
// Applies add or set to the counter, clamps at zero, rejects values that need
// too many digits, and pushes the outcome into the request queue.
// ----------------------------------------------------------------------------
module ddc_front
  import ddc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             in_op,
  input  logic [AMT_W-1:0] in_amount,
  input  ddc_qstat_t       qstat,
  output logic             push,
  output ddc_entry_t       push_entry
);

  logic [COUNT_W-1:0] counter_r;
  logic [COUNT_W-1:0] counter_nxt;
  logic [SUM_W-1:0]   amt_ext;
  logic [SUM_W-1:0]   sum;
  logic               non_positive;
  logic               too_big;

  assign in_ready = !qstat.full;
  assign push     = in_valid && in_ready;

  assign amt_ext = {{(SUM_W - AMT_W){in_amount[AMT_W-1]}}, in_amount};

  always_comb begin
    if (in_op == OP_SET) begin
      sum = amt_ext;
    end else begin
      sum = {{(SUM_W - COUNT_W){1'b0}}, counter_r} + amt_ext;
    end
    non_positive = sum[SUM_W-1] || (sum == '0);
    too_big      = !sum[SUM_W-1] && (sum > LIMIT);
    if (non_positive) begin
      counter_nxt = '0;
    end else if (too_big) begin
      counter_nxt = counter_r;
    end else begin
      counter_nxt = sum[COUNT_W-1:0];
    end
  end

  assign push_entry.rejected = too_big;
  assign push_entry.count    = counter_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      counter_r <= '0;
    end else if (push) begin
      counter_r <= counter_nxt;
    end
  end

endmodule

@@ src/ddc_queue.sv @@
// ----------------------------------------------------------------------------
// ddc_queue: short request queue
// A small first-in first-out buffer between the front end and the converter.
// ----------------------------------------------------------------------------
module ddc_queue
  import ddc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  ddc_entry_t push_entry,
  input  logic       pop,
  output ddc_entry_t pop_entry,
  output ddc_qstat_t qstat
);

  ddc_entry_t      mem_r [QDEPTH];
  logic [QA_W-1:0] wr_ptr_r;
  logic [QA_W-1:0] rd_ptr_r;
  logic [QA_W:0]   fill_r;

  assign qstat.full  = (fill_r == (QA_W + 1)'(QDEPTH));
  assign qstat.empty = (fill_r == '0);
  assign pop_entry   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QA_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QA_W'(1);
      end
      if (push && !pop) begin
        fill_r <= fill_r + (QA_W + 1)'(1);
      end else if (pop && !push) begin
        fill_r <= fill_r - (QA_W + 1)'(1);
      end
    end
  end

endmodule

@@ src/ddc_back.sv @@
// ----------------------------------------------------------------------------
// ddc_back: decimal converter and result register
// Converts one queued value to decimal, one bit per cycle with shift-add-3,
// builds the visibility mask and holds the result until it is taken.
// ----------------------------------------------------------------------------
module ddc_back
  import ddc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  ddc_qstat_t       qstat,
  input  ddc_entry_t       pop_entry,
  output logic             pop,
  input  logic             lzf,
  input  logic [FDC_W-1:0] fdc,
  output logic             out_valid,
  input  logic             out_ready,
  output ddc_result_t      out_result,
  output logic             out_rejected
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_CONV = 3'b010,
    ST_DONE = 3'b100
  } bk_state_t;

  bk_state_t          state_r;
  bk_state_t          state_nxt;
  logic [STEP_W-1:0]  step_r;
  logic [COUNT_W-1:0] bin_r;
  logic [COUNT_W-1:0] count_r;
  logic               rej_r;
  logic [BCD_W-1:0]   bcd_r;
  logic [BCD_W-1:0]   bcd_nxt;
  logic               out_valid_r;
  ddc_result_t        res_r;
  logic               res_rej_r;
  ddc_result_t        res_nxt;
  logic               load_out;
  logic [FDC_W-1:0]   shown;
  logic               any_above;

  // Add 3 to every digit of 5 or more; the caller then shifts in the next binary bit.
  function automatic logic [BCD_W-1:0] dabble(input logic [BCD_W-1:0] v);
    logic [BCD_W-1:0] r;
    r = v;
    for (int i = 0; i < DIGITS; i++) begin
      if (r[4*i +: 4] >= 4'd5) begin
        r[4*i +: 4] = r[4*i +: 4] + 4'd3;
      end
    end
    return r;
  endfunction

  always_comb begin
    bcd_nxt = dabble(bcd_r);
    bcd_nxt = {bcd_nxt[BCD_W-2:0], bin_r[COUNT_W-1]};
  end

  assign pop      = (state_r == ST_IDLE) && !qstat.empty;
  assign load_out = (state_r == ST_DONE) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (!qstat.empty) state_nxt = ST_CONV;
      ST_CONV: if (step_r == STEP_W'(1)) state_nxt = ST_DONE;
      ST_DONE: if (load_out) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Result formatting: digits and the mask of shown positions.
  always_comb begin
    shown     = (fdc > FDC_W'(DIGITS)) ? FDC_W'(DIGITS) : fdc;
    any_above = 1'b0;
    res_nxt   = '0;
    res_nxt.count = count_r;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (i < DIGITS) begin
        res_nxt.digits[i] = bcd_r[4*i +: 4];
        any_above = any_above || (bcd_r[4*i +: 4] != 4'd0);
        if (i == 0) begin
          res_nxt.mask[i] = 1'b1;
        end else if (lzf) begin
          res_nxt.mask[i] = (FDC_W'(i) < shown);
        end else begin
          res_nxt.mask[i] = any_above;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      bin_r   <= pop_entry.count;
      count_r <= pop_entry.count;
      rej_r   <= pop_entry.rejected;
      bcd_r   <= '0;
    end else if (state_r == ST_CONV) begin
      bin_r <= {bin_r[COUNT_W-2:0], 1'b0};
      bcd_r <= bcd_nxt;
    end
    if (load_out) begin
      res_r     <= res_nxt;
      res_rej_r <= rej_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (pop) begin
        step_r <= STEP_W'(COUNT_W);
      end else if (state_r == ST_CONV) begin
        step_r <= step_r - STEP_W'(1);
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid    = out_valid_r;
  assign out_result   = res_r;
  assign out_rejected = res_rej_r;

endmodule

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// tb: self-checking bench for the decimal display counter
// Requests that add to or set the counter are sent with random gaps. Each
// result is checked field by field against a cycle-free predictor of the
// counter, its decimal digits, the blanking mask and the reject flag.
// Several display settings are applied between phases, while the block is
// idle.
// ----------------------------------------------------------------------------
module tb;
  import ddc_pkg::*;

  // The settle wait is the conversion time of one request plus a margin,
  // which covers a request that is still in flight.
  localparam int LATENCY      = 29;
  localparam int SETTLE_WAIT  = LATENCY + 11;
  localparam int CYCLE_LIMIT  = 500000;
  localparam int PHASES       = 6;
  localparam int PHASE_ITEMS  = 255;
  localparam int DIRECTED     = 22;
  localparam int DISPLAY_MAX  = 10 ** DIGITS - 1;

  // Register indexes that the block does not implement; writes to them
  // must leave the display settings unchanged.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = CFG_IDX_W'(3);

  // One decoded result, in the order the result bus carries the fields.
  typedef struct {
    logic [COUNT_W-1:0] count;
    logic [3:0]         digit [SLOTS];
    logic [SLOTS-1:0]   mask;
    logic [4:0]         pad;
    logic               rejected;
  } display_t;

  // Holds the predicted counter and display settings, and the queue of
  // displays that the block still owes.
  class display_checker;
    bit                 fill_on;
    logic [FDC_W-1:0]   fixed_count;
    logic [COUNT_W-1:0] counter_value;
    display_t           expected_displays[$];
    int                 errors;

    function new();
      fill_on       = 1'b0;
      fixed_count   = FDC_W'(8);
      counter_value = '0;
      errors        = 0;
    endfunction

    function void write_register(logic [CFG_IDX_W-1:0] index, logic [FDC_W-1:0] data);
      case (index)
        CFG_LEADING_ZERO_FILL: fill_on = data[0];
        CFG_FIXED_DIGIT_COUNT: fixed_count = data;
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_displays.size();
    endfunction

    // Applies one accepted request to the counter and queues the display.
    function void note_request(logic op, logic signed [AMT_W-1:0] amount);
      longint   next_value;
      longint   rest;
      int       shown;
      display_t want;
      if (op == OP_ADD)
        next_value = longint'(counter_value) + longint'(amount);
      else
        next_value = longint'(amount);
      want.rejected = 1'b0;
      if (next_value <= 0)
        counter_value = '0;
      else if (next_value > DISPLAY_MAX)
        want.rejected = 1'b1;
      else
        counter_value = COUNT_W'(next_value);
      want.count = counter_value;
      want.pad   = '0;
      rest = longint'(counter_value);
      for (int i = 0; i < SLOTS; i++) begin
        want.digit[i] = (i < DIGITS) ? 4'(rest % 10) : 4'd0;
        rest = rest / 10;
      end
      // Fixed mode saturates at the digit count; otherwise only the
      // significant digits are shown. The units digit is always shown.
      if (fill_on) begin
        shown = (fixed_count > DIGITS) ? DIGITS : int'(fixed_count);
      end else begin
        shown = 0;
        rest  = longint'(counter_value);
        while (rest != 0) begin
          shown++;
          rest = rest / 10;
        end
      end
      want.mask    = '0;
      want.mask[0] = 1'b1;
      for (int i = 0; i < shown; i++)
        want.mask[i] = 1'b1;
      expected_displays.push_back(want);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      end
    endfunction

    function void check_result(logic [71:0] tdata, logic tuser);
      display_t want;
      if (expected_displays.size() == 0) begin
        errors++;
        $display("%0t: result with no request pending, expected none, got %h", $time, tdata);
        return;
      end
      want = expected_displays.pop_front();
      compare_field("count", 32'(want.count), 32'(tdata[COUNT_W-1:0]));
      for (int i = 0; i < SLOTS; i++)
        compare_field($sformatf("digit_%0d", i), 32'(want.digit[i]),
                      32'(tdata[COUNT_W + 4*i +: 4]));
      compare_field("visible_mask", 32'(want.mask), 32'(tdata[COUNT_W + 4*SLOTS +: SLOTS]));
      compare_field("padding", 32'(want.pad), 32'(tdata[71 -: 5]));
      compare_field("rejected", 32'(want.rejected), 32'(tuser));
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [FDC_W-1:0]     cfg_data;
  logic                 in_tvalid;
  logic                 in_tready;
  logic [31:0]          in_tdata;
  logic                 in_tuser;
  logic                 out_tvalid;
  logic                 out_tready;
  logic [71:0]          out_tdata;
  logic                 out_tuser;

  display_checker sb;
  int             cycles = 0;
  int             calm_left [2] = '{0, 0};
  int             out_hold = 0;
  bit             took_result = 1'b0;

  decimal_display_counter i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Draws the idle cycles before the next request on one side (0 for the
  // sender, 1 for the receiver). Now and then a calm stretch of 11 to 41
  // draws runs with no idling at all.
  function automatic int idle_draw(int side);
    if (calm_left[side] > 0) begin
      calm_left[side]--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) begin
      calm_left[side] = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 7);
  endfunction

  // Picks one random request. Most of them keep the counter inside the
  // display range and walk it to both of its edges, so that clamping to
  // zero and rejection at the digit limit happen often.
  function automatic void draw_request(output logic op, output logic signed [31:0] amount);
    int digits;
    int magnitude;
    case ($urandom_range(0, 9))
      0: begin
        digits = $urandom_range(1, DIGITS);
        op     = OP_SET;
        amount = 32'($urandom_range(10 ** (digits - 1), 10 ** digits - 1));
      end
      1, 2, 3: begin
        op     = OP_ADD;
        amount = 32'(int'($urandom_range(0, 2000)) - 1000);
      end
      4: begin
        digits    = $urandom_range(0, DIGITS);
        magnitude = $urandom_range(0, 10 ** digits);
        op        = OP_ADD;
        amount    = $urandom_range(0, 1) ? 32'(magnitude) : 32'(-magnitude);
      end
      5: begin
        op     = 1'($urandom);
        amount = 32'($urandom);
      end
      6: begin
        op     = OP_SET;
        amount = 32'(DISPLAY_MAX + int'($urandom_range(0, 6)) - 3);
      end
      7: begin
        // Land on or just beside the largest value that fits.
        op     = OP_ADD;
        amount = 32'(DISPLAY_MAX - int'(sb.counter_value) + int'($urandom_range(0, 2)) - 1);
      end
      8: begin
        // Land on or just beside zero.
        op     = OP_ADD;
        amount = 32'(int'($urandom_range(0, 2)) - 1 - int'(sb.counter_value));
      end
      default: begin
        op     = OP_SET;
        amount = $urandom_range(0, 1) ? 32'(-int'($urandom_range(0, 5)))
                                      : (32'h8000_0000 | 32'($urandom));
      end
    endcase
  endfunction

  // Sends one request after a random gap; valid stays high into the next
  // request when that one has no gap.
  task automatic send_request(logic op, logic signed [31:0] amount);
    int gap;
    gap = idle_draw(0);
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser  = op;
    in_tdata  = amount;
    do @(posedge clk); while (!in_tready);
    sb.note_request(op, amount);
  endtask

  task automatic program_register(logic [CFG_IDX_W-1:0] index, logic [FDC_W-1:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = index;
    cfg_data  = data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_register(index, data);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Waits until every owed display has arrived, then lets the block's
  // latency pass so that nothing is still in flight.
  task automatic settle();
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_WAIT) @(posedge clk);
  endtask

  // Result side: every accepted display is checked at the rising edge, and
  // the receiver then stalls for a random number of cycles.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      sb.check_result(out_tdata, out_tuser);
      took_result = 1'b1;
    end
  end

  always @(negedge clk) begin
    if (took_result) begin
      took_result = 1'b0;
      out_hold    = idle_draw(1);
    end
    if (out_hold > 0) begin
      out_tready = 1'b0;
      out_hold--;
    end else begin
      out_tready = 1'b1;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    logic              dir_op [DIRECTED];
    logic signed [31:0] dir_amount [DIRECTED];
    bit                fill_plan [PHASES];
    int                count_plan [PHASES];
    logic              op;
    logic signed [31:0] amount;

    // Directed requests: zero, both ends of the display range, one past
    // it, the most negative and most positive amounts, a sum that falls
    // below zero, and values with one, two, three, seven and eight digits.
    dir_op = '{OP_SET, OP_ADD, OP_ADD, OP_SET, OP_ADD, OP_ADD, OP_SET, OP_SET,
               OP_SET, OP_SET, OP_SET, OP_ADD, OP_ADD, OP_SET, OP_ADD, OP_SET,
               OP_SET, OP_SET, OP_SET, OP_ADD, OP_SET, OP_ADD};
    dir_amount = '{32'sd0, 32'sd0, 32'sd1, 32'sd99999999, 32'sd1, -32'sd1,
                   32'sd100000000, -32'sd1, 32'sh8000_0000, 32'sh7fff_ffff,
                   32'sd12345678, 32'sh8000_0000, 32'sh7fff_ffff, 32'sd5,
                   -32'sd5, 32'sd9, 32'sd10, 32'sd999, 32'sd1000000,
                   -32'sd999999, 32'sd87654321, 32'sd12345678};

    // Display settings per phase, the extremes of the fixed count among
    // them; a count above the digit count must saturate.
    fill_plan  = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0};
    count_plan = '{8, 0, 15, 15, 5, 0};

    sb         = new();
    rst_n      = 1'b0;
    cfg_valid  = 1'b0;
    cfg_index  = CFG_LEADING_ZERO_FILL;
    cfg_data   = '0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = OP_ADD;
    out_tready = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // The directed part runs with the reset settings: blanking of leading
    // zeros and a fixed count of eight.
    for (int i = 0; i < DIRECTED; i++)
      send_request(dir_op[i], dir_amount[i]);

    for (int p = 0; p < PHASES; p++) begin
      @(negedge clk);
      in_tvalid = 1'b0;
      settle();
      program_register(CFG_LEADING_ZERO_FILL, FDC_W'(fill_plan[p]));
      program_register(CFG_FIXED_DIGIT_COUNT, FDC_W'(count_plan[p]));
      program_register((p % 2 == 0) ? CFG_SPARE_A : CFG_SPARE_B, FDC_W'($urandom));
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        draw_request(op, amount);
        send_request(op, amount);
      end
    end
    @(negedge clk);
    in_tvalid = 1'b0;

    settle();
    if (sb.errors == 0 && sb.pending() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule

@@ decimal_display_counter.f @@
src/ddc_pkg.sv
src/ddc_front.sv
src/ddc_queue.sv
src/ddc_back.sv
src/decimal_display_counter.sv
tb/tb.sv
